// ===== rtl/core/imupd_pkg.sv =====
`default_nettype none

package imupd_pkg;

  localparam int unsigned FRAME_LENGTH = 11;
  // header is not kept; type byte plus eight payload bytes are
  localparam int unsigned STORED_BYTES = FRAME_LENGTH - 2;
  localparam int unsigned QUEUE_DEPTH  = 2;
  localparam int unsigned TURN_BITS    = 16;

  localparam logic [7:0] HEADER_BYTE = 8'h55;
  localparam logic [7:0] TYPE_ACC    = 8'h51;
  localparam logic [7:0] TYPE_GYRO   = 8'h52;
  localparam logic [7:0] TYPE_ANGLE  = 8'h53;

  localparam logic [15:0] YAW_HOLD_POS = 16'h7FFF;
  localparam logic [15:0] YAW_HOLD_NEG = 16'h8000;
  localparam int          HALF_TURN    = 32768;

  typedef enum logic [1:0] {
    KIND_ACC   = 2'd0,
    KIND_GYRO  = 2'd1,
    KIND_ANGLE = 2'd2
  } kind_e;

  typedef struct packed {
    kind_e       kind;
    logic [15:0] word_x;
    logic [15:0] word_y;
    logic [15:0] word_z;
    logic [15:0] word_temp;
  } frame_t;

  // queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } queue_status_t;

endpackage

`default_nettype wire

// ===== rtl/core/imupd_front.sv =====
`default_nettype none

module imupd_front (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               in_valid_i,
  output logic                    in_stall_o,
  input  wire logic [7:0]         rx_byte_i,
  input  wire imupd_pkg::queue_status_t q_status_i,
  output logic                    push_o,
  output imupd_pkg::frame_t       push_frame_o
);

  localparam int unsigned IdxW = $clog2(imupd_pkg::STORED_BYTES);

  logic [3:0] count_q, count_d;
  logic [7:0] frame_q [imupd_pkg::STORED_BYTES];
  logic       accept;
  logic       last_byte;
  logic       kind_ok;
  imupd_pkg::kind_e kind;

  assign in_stall_o = q_status_i.full;
  assign accept     = in_valid_i && !in_stall_o;
  assign last_byte  = (count_q == 4'(imupd_pkg::STORED_BYTES + 1));

  always_comb begin
    kind_ok = 1'b1;
    kind    = imupd_pkg::KIND_ACC;
    unique case (frame_q[0])
      imupd_pkg::TYPE_ACC:   kind = imupd_pkg::KIND_ACC;
      imupd_pkg::TYPE_GYRO:  kind = imupd_pkg::KIND_GYRO;
      imupd_pkg::TYPE_ANGLE: kind = imupd_pkg::KIND_ANGLE;
      default:               kind_ok = 1'b0;
    endcase
  end

  always_comb begin
    count_d = count_q;
    if (accept) begin
      if (count_q == 4'd0) begin
        if (rx_byte_i == imupd_pkg::HEADER_BYTE) begin
          count_d = 4'd1;
        end
      end else if (last_byte) begin
        count_d = 4'd0;
      end else begin
        count_d = count_q + 4'd1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= 4'd0;
    end else begin
      count_q <= count_d;
    end
  end

  // byte k of the frame (k >= 1) lands at slot k-1
  always_ff @(posedge clk_i) begin
    if (accept && count_q != 4'd0 && !last_byte) begin
      frame_q[IdxW'(count_q - 4'd1)] <= rx_byte_i;
    end
  end

  // checksum byte closes the frame; it is never checked
  assign push_o                 = accept && last_byte && kind_ok;
  assign push_frame_o.kind      = kind;
  assign push_frame_o.word_x    = {frame_q[2], frame_q[1]};
  assign push_frame_o.word_y    = {frame_q[4], frame_q[3]};
  assign push_frame_o.word_z    = {frame_q[6], frame_q[5]};
  assign push_frame_o.word_temp = {frame_q[8], frame_q[7]};

endmodule

`default_nettype wire

// ===== rtl/core/imupd_fifo.sv =====
`default_nettype none

module imupd_fifo (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  input  wire logic               push_i,
  input  wire imupd_pkg::frame_t  push_frame_i,
  input  wire logic               pop_i,
  output imupd_pkg::frame_t       pop_frame_o,
  output imupd_pkg::queue_status_t status_o
);

  localparam int unsigned Depth = imupd_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW  = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW  = $clog2(Depth + 1);

  imupd_pkg::frame_t mem_q [Depth];
  logic [PtrW-1:0]   wr_ptr_q, rd_ptr_q;
  logic [CntW-1:0]   count_q;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    ptr_inc = (p == PtrW'(Depth - 1)) ? '0 : p + PtrW'(1);
  endfunction

  assign status_o.full  = (count_q == CntW'(Depth));
  assign status_o.empty = (count_q == '0);
  assign pop_frame_o    = mem_q[rd_ptr_q];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= ptr_inc(wr_ptr_q);
      end
      if (pop_i) begin
        rd_ptr_q <= ptr_inc(rd_ptr_q);
      end
      if (push_i && !pop_i) begin
        count_q <= count_q + CntW'(1);
      end else if (pop_i && !push_i) begin
        count_q <= count_q - CntW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= push_frame_i;
    end
  end

  a_no_overflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    push_i |-> !status_o.full)
    else $error("queue push while full");

  a_no_underflow : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_i |-> !status_o.empty)
    else $error("queue pop while empty");

  a_count_range : assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= CntW'(Depth))
    else $error("queue count out of range");

endmodule

`default_nettype wire

// ===== rtl/core/imupd_back.sv =====
`default_nettype none

module imupd_back #(
  parameter int unsigned TurnBits = imupd_pkg::TURN_BITS
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire imupd_pkg::queue_status_t q_status_i,
  input  wire imupd_pkg::frame_t   frame_i,
  output logic                     pop_o,
  output logic                     out_valid_o,
  input  wire logic                out_stall_i,
  output logic [1:0]               packet_kind_o,
  output logic signed [15:0]       word_x_o,
  output logic signed [15:0]       word_y_o,
  output logic signed [15:0]       word_z_o,
  output logic signed [15:0]       word_temp_o,
  output logic [15:0]              yaw_unsigned_o,
  output logic signed [15:0]       turn_total_o,
  output logic signed [31:0]       multi_turn_angle_o
);

  logic                 out_valid_q;
  imupd_pkg::frame_t    frame_q;
  logic [15:0]          yaw_q, yaw_d;
  logic [TurnBits-1:0]  turn_q, turn_d;
  logic [15:0]          out_yaw_q;
  logic [15:0]          out_turn_q;
  logic                 is_angle;
  logic                 yaw_hold;
  logic signed [16:0]   diff;
  logic [15:0]          turn_ext;

  assign pop_o    = !q_status_i.empty && (!out_valid_q || !out_stall_i);
  assign is_angle = (frame_i.kind == imupd_pkg::KIND_ANGLE);
  assign yaw_hold = (frame_i.word_z == imupd_pkg::YAW_HOLD_POS) ||
                    (frame_i.word_z == imupd_pkg::YAW_HOLD_NEG);

  // previous yaw always equals held yaw, so one register serves both
  always_comb begin
    yaw_d  = yaw_q;
    turn_d = turn_q;
    diff   = '0;
    if (is_angle) begin
      if (!yaw_hold) begin
        yaw_d = frame_i.word_z;
      end
      diff = $signed({1'b0, yaw_d}) - $signed({1'b0, yaw_q});
      if (diff > 17'sd32768) begin
        turn_d = turn_q - TurnBits'(1);
      end else if (diff < -17'sd32768) begin
        turn_d = turn_q + TurnBits'(1);
      end
    end
  end

  assign turn_ext = 16'($signed(turn_d));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      yaw_q       <= '0;
      turn_q      <= '0;
    end else begin
      if (pop_o) begin
        out_valid_q <= 1'b1;
        yaw_q       <= yaw_d;
        turn_q      <= turn_d;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (pop_o) begin
      frame_q    <= frame_i;
      out_yaw_q  <= yaw_d;
      out_turn_q <= turn_ext;
    end
  end

  assign out_valid_o        = out_valid_q;
  assign packet_kind_o      = frame_q.kind;
  assign word_x_o           = frame_q.word_x;
  assign word_y_o           = frame_q.word_y;
  assign word_z_o           = frame_q.word_z;
  assign word_temp_o        = frame_q.word_temp;
  assign yaw_unsigned_o     = out_yaw_q;
  assign turn_total_o       = out_turn_q;
  assign multi_turn_angle_o = {out_turn_q, out_yaw_q};

  a_sentinel_keeps_yaw : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && is_angle && yaw_hold |=> $stable(yaw_q))
    else $error("yaw changed on a sentinel value");

  a_plain_frame_keeps_turns : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o && !is_angle |=> $stable(turn_q) && $stable(yaw_q))
    else $error("yaw state changed on a non-angle frame");

  a_pop_loads_output : assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> out_valid_q && yaw_unsigned_o == yaw_q)
    else $error("output register not loaded on pop");

endmodule

`default_nettype wire

// ===== rtl/core/imu_packet_deframer_yaw_unwrap.sv =====
// Serial IMU frame deframer with multi-turn yaw tracking.
// Input channel: one received byte per transfer on rx_byte_i (in_valid_i /
// in_stall_o). The block hunts for the 0x55 header, collects 11-byte
// frames and drops the checksum byte unchecked.
// Output channel: one transfer per complete frame of type 0x51, 0x52 or
// 0x53 (out_valid_o / out_stall_i) with the four raw payload words, the
// held yaw, the turn counter and the combined multi-turn angle.
// With the output free, the result of a frame passes the frame queue and
// the output register. Throughput: one byte per cycle while in_stall_o
// is low; the front deframer and the back yaw unit each take one item
// per cycle when not stalled and meet through a two-entry frame queue.
// Reset clears the byte counter, the queue, the yaw and the turn count;
// the first frame after reset is hunted from its header.
// When the receiver stalls the result holds on the output; further frames
// fill the queue, and in_stall_o rises only while the queue is full.
`default_nettype none

module imu_packet_deframer_yaw_unwrap #(
  parameter int unsigned TurnBits = imupd_pkg::TURN_BITS
) (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          in_valid_i,
  output logic               in_stall_o,
  input  wire logic [7:0]    rx_byte_i,
  output logic               out_valid_o,
  input  wire logic          out_stall_i,
  output logic [1:0]         packet_kind_o,
  output logic signed [15:0] word_x_o,
  output logic signed [15:0] word_y_o,
  output logic signed [15:0] word_z_o,
  output logic signed [15:0] word_temp_o,
  output logic [15:0]        yaw_unsigned_o,
  output logic signed [15:0] turn_total_o,
  output logic signed [31:0] multi_turn_angle_o
);

  imupd_pkg::queue_status_t q_status;
  imupd_pkg::frame_t        push_frame;
  imupd_pkg::frame_t        pop_frame;
  logic                     push;
  logic                     pop;

  imupd_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .rx_byte_i    (rx_byte_i),
    .q_status_i   (q_status),
    .push_o       (push),
    .push_frame_o (push_frame)
  );

  imupd_fifo u_fifo (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .push_frame_i (push_frame),
    .pop_i        (pop),
    .pop_frame_o  (pop_frame),
    .status_o     (q_status)
  );

  imupd_back #(
    .TurnBits (TurnBits)
  ) u_back (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .q_status_i         (q_status),
    .frame_i            (pop_frame),
    .pop_o              (pop),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .packet_kind_o      (packet_kind_o),
    .word_x_o           (word_x_o),
    .word_y_o           (word_y_o),
    .word_z_o           (word_z_o),
    .word_temp_o        (word_temp_o),
    .yaw_unsigned_o     (yaw_unsigned_o),
    .turn_total_o       (turn_total_o),
    .multi_turn_angle_o (multi_turn_angle_o)
  );

endmodule

`default_nettype wire
